[design/pdc_pkg.sv]
// shared constants and types for the pwm duty capture block
package pdc_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int CFG_WIDTH   = 32;
    localparam int DUTY_WIDTH  = 8;
    localparam int DIV_STEPS   = DUTY_WIDTH;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [CFG_WIDTH-1:0]   TIMEOUT_RESET = CFG_WIDTH'(4800000);
    localparam logic [DUTY_WIDTH-1:0]  DUTY_FULL     = {DUTY_WIDTH{1'b1}};
    localparam logic [DUTY_WIDTH-1:0]  DUTY_ZERO     = '0;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX     = {COUNT_WIDTH{1'b1}};

    // divider result seen by the sequencer
    typedef struct packed {
        logic                  done;
        logic [DUTY_WIDTH-1:0] quot;
    } pdc_div_res_t;

endpackage

[design/pdc_div.sv]
// iterative restoring divider for high*255/period, one quotient bit per cycle
module pdc_div
    import pdc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [COUNT_WIDTH-1:0] high,
    input  logic [COUNT_WIDTH-1:0] period,
    output pdc_div_res_t           res
);

    logic                       busy_reg;
    logic                       done_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [COUNT_WIDTH-1:0]     rem_reg;
    logic [COUNT_WIDTH-1:0]     divisor_reg;
    logic [DIV_STEPS-1:0]       lo_reg;
    logic [DUTY_WIDTH-1:0]      quot_reg;

    logic [COUNT_WIDTH+DIV_STEPS-1:0] prod;
    logic [COUNT_WIDTH:0]             trial;
    logic [COUNT_WIDTH:0]             diff;
    logic                             ge;
    logic [COUNT_WIDTH-1:0]           rem_next;

    // dividend high*255 as high*256 - high
    assign prod = {high, {DIV_STEPS{1'b0}}} - (COUNT_WIDTH + DIV_STEPS)'(high);

    // one restoring step: shift in next dividend bit, trial subtract
    assign trial    = {rem_reg, lo_reg[DIV_STEPS-1]};
    assign diff     = trial - {1'b0, divisor_reg};
    assign ge       = (trial >= {1'b0, divisor_reg});
    assign rem_next = ge ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (step_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath, top dividend bits start below the divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= prod[COUNT_WIDTH+DIV_STEPS-1:DIV_STEPS];
            lo_reg      <= prod[DIV_STEPS-1:0];
            divisor_reg <= period;
            quot_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            lo_reg   <= {lo_reg[DIV_STEPS-2:0], 1'b0};
            quot_reg <= {quot_reg[DUTY_WIDTH-2:0], ge};
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;

endmodule

[design/pwm_duty_capture.sv]
// pwm duty capture top level: tick counting, edge captures, read sequencer
// tick beat: ticks may arrive every cycle while the input is not stalled
// read beat: result through the 8-step divider, or without it when idle,
//   no period captured or high time not below the period; input stalled meanwhile
// next beat taken once the sequencer is back in idle, later only while the output holds a stalled beat
// reset: async active low, clears counters, captures, flags, timeout to 4800000
module pwm_duty_capture
    import pdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_WIDTH-1:0]  cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  action,
    input  logic                  pin_level,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DUTY_WIDTH-1:0] duty,
    output logic                  idle_flag
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic                   out_valid_reg;
    logic [DUTY_WIDTH-1:0]  duty_reg;
    logic                   idle_flag_reg;
    logic [DUTY_WIDTH-1:0]  res_duty_reg;
    logic                   res_idle_reg;

    logic [CFG_WIDTH-1:0]   idle_timeout_reg;
    logic [COUNT_WIDTH-1:0] tick_count_reg;
    logic [COUNT_WIDTH-1:0] period_reg;
    logic [COUNT_WIDTH-1:0] high_reg;
    logic                   prev_level_reg;
    logic                   idle_mark_reg;
    logic                   held_level_reg;

    logic                   accept;
    logic                   tick_acc;
    logic                   read_acc;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   changed;
    logic                   rising;
    logic                   falling;
    logic                   timeout_hit;
    logic                   div_start;
    pdc_div_res_t           div_res;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign tick_acc = accept && !action;
    assign read_acc = accept && action;

    // saturating count and edge detect
    assign changed     = (tick_count_reg != COUNT_MAX);
    assign count_next  = changed ? tick_count_reg + 1'b1 : tick_count_reg;
    assign rising      = pin_level && !prev_level_reg;
    assign falling     = !pin_level && prev_level_reg;
    assign timeout_hit = changed && (CFG_WIDTH'(count_next) == idle_timeout_reg);

    // divider runs only for a real fraction below one
    assign div_start = read_acc && !idle_mark_reg && (period_reg != '0)
                       && (high_reg < period_reg);

    pdc_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .high   (high_reg),
        .period (period_reg),
        .res    (div_res)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wen)
        begin
            idle_timeout_reg <= cfg_wdata;
        end
    end

    // tick processing: captures, restart, timeout
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            period_reg     <= '0;
            high_reg       <= '0;
            prev_level_reg <= 1'b0;
            idle_mark_reg  <= 1'b0;
            held_level_reg <= 1'b0;
        end
        else if (tick_acc)
        begin
            prev_level_reg <= pin_level;
            if (rising)
            begin
                period_reg     <= count_next;
                tick_count_reg <= '0;
                idle_mark_reg  <= 1'b0;
            end
            else
            begin
                tick_count_reg <= count_next;
                if (falling)
                begin
                    high_reg <= count_next;
                end
                if (timeout_hit)
                begin
                    idle_mark_reg  <= 1'b1;
                    held_level_reg <= pin_level;
                end
            end
        end
    end

    // read sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            duty_reg      <= '0;
            idle_flag_reg <= 1'b0;
            res_duty_reg  <= '0;
            res_idle_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (read_acc)
                    begin
                        priority if (idle_mark_reg)
                        begin
                            res_duty_reg <= held_level_reg ? DUTY_FULL : DUTY_ZERO;
                            res_idle_reg <= 1'b1;
                            state_reg    <= ST_DONE;
                        end
                        else if (period_reg == '0)
                        begin
                            res_duty_reg <= DUTY_ZERO;
                            res_idle_reg <= 1'b0;
                            state_reg    <= ST_DONE;
                        end
                        else if (high_reg >= period_reg)
                        begin
                            res_duty_reg <= DUTY_FULL;
                            res_idle_reg <= 1'b0;
                            state_reg    <= ST_DONE;
                        end
                        else
                        begin
                            res_idle_reg <= 1'b0;
                            state_reg    <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_res.done)
                    begin
                        res_duty_reg <= div_res.quot;
                        state_reg    <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    // load the beat once the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        duty_reg      <= res_duty_reg;
                        idle_flag_reg <= res_idle_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign duty      = duty_reg;
    assign idle_flag = idle_flag_reg;

endmodule

[design/pdc_checker.sv]
// port level checks for the pwm duty capture block, bound to the top level
module pdc_checker
    import pdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  action,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [DUTY_WIDTH-1:0] duty,
    input  logic                  idle_flag
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(duty) && $stable(idle_flag))
        else $error("stalled result beat changed");

    // an idle result reports only the latched level
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && idle_flag |-> (duty == DUTY_FULL) || (duty == DUTY_ZERO))
        else $error("idle result with partial duty");

    // a read beat keeps the input side busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action |=> in_stall)
        else $error("input taken right after a read beat");

    // a tick beat never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && in_valid && !in_stall && !action |=> !out_valid)
        else $error("result appeared after a tick beat");

endmodule

bind pwm_duty_capture pdc_checker u_pdc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .duty      (duty),
    .idle_flag (idle_flag)
);
